@@ hw/rtl/clp_pkg.sv @@
// Package for the log line parser: widths, character codes, the line state and the result
// record. It has no dependencies and is shared by the parser core and the top level.
`default_nettype none

package clp_pkg;

    localparam int LINE_CAPACITY = 80;
    localparam int MAX_BYTES     = 8;

    localparam int LINE_LEN_W = $clog2(LINE_CAPACITY);
    localparam int COUNT_W    = 4;
    localparam int ID_W       = 32;
    localparam int DATA_W     = 64;
    localparam int CHAR_W     = 8;

    localparam logic [LINE_LEN_W-1:0] LINE_KEEP_MAX = LINE_LEN_W'(LINE_CAPACITY - 1);
    localparam logic [COUNT_W-1:0]    BYTE_LIMIT    = COUNT_W'(MAX_BYTES);

    localparam logic [CHAR_W-1:0] CHAR_HASH  = 8'h23;
    localparam logic [CHAR_W-1:0] CHAR_BANG  = 8'h21;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;

    localparam logic [1:0] PHASE_NONE  = 2'd0;
    localparam logic [1:0] PHASE_DIGIT = 2'd1;
    localparam logic [1:0] PHASE_OTHER = 2'd2;

    localparam logic EVENT_FRAME = 1'b0;
    localparam logic EVENT_STOP  = 1'b1;

    typedef struct packed {
        logic [LINE_LEN_W-1:0] line_length;
        logic                  first_is_bang;
        logic                  hash_seen;
        logic [ID_W-1:0]       token_value;
        logic                  token_ended;
        logic [ID_W-1:0]       latched_id;
        logic [DATA_W-1:0]     data_bytes;
        logic [COUNT_W-1:0]    data_count;
        logic [1:0]            pair_phase;
        logic [3:0]            high_nibble;
        logic                  data_done;
    } clp_state_t;

    typedef struct packed {
        logic               event_kind;
        logic [ID_W-1:0]    frame_id;
        logic [COUNT_W-1:0] byte_count;
        logic [DATA_W-1:0]  payload;
    } clp_result_t;

    typedef struct packed {
        logic is_hex;
        logic [3:0] value;
    } clp_hex_t;

    function automatic clp_hex_t hex_decode(input logic [CHAR_W-1:0] c);
        clp_hex_t h;
        h.is_hex = 1'b1;
        h.value  = 4'h0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.value = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.value = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.value = 4'(c - 8'h37);
        end else begin
            h.is_hex = 1'b0;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/clp_line_core.sv @@
// Combinational parsing step: from the current line state and one character it forms the
// next line state and any result. Depends on clp_pkg.
`default_nettype none

module clp_line_core (
    input  wire logic                  play_en,
    input  wire logic [7:0]            char_in,
    input  wire clp_pkg::clp_state_t   cur_state,
    output clp_pkg::clp_state_t        next_state,
    output logic                       emit,
    output logic                       stop,
    output clp_pkg::clp_result_t       result
);
    import clp_pkg::*;

    function automatic clp_state_t store_byte(input clp_state_t s, input logic [7:0] b);
        clp_state_t r;
        r = s;
        for (int i = 0; i < MAX_BYTES; i++) begin
            if (s.data_count == COUNT_W'(i)) begin
                r.data_bytes[i*8 +: 8] = b;
            end
        end
        if (s.data_count < BYTE_LIMIT) begin
            r.data_count = s.data_count + 1'b1;
        end
        r.pair_phase = PHASE_NONE;
        if (r.data_count >= BYTE_LIMIT) begin
            r.data_done = 1'b1;
        end
        return r;
    endfunction

    clp_hex_t   hex;
    clp_state_t fin;
    logic       is_eol;

    assign hex    = hex_decode(char_in);
    assign is_eol = (char_in == CHAR_LF) || (char_in == CHAR_CR);

    always_comb begin
        next_state = cur_state;
        fin        = cur_state;
        emit       = 1'b0;
        stop       = 1'b0;
        result     = '0;
        if (play_en) begin
            if (is_eol) begin
                if (cur_state.line_length != '0) begin
                    if (cur_state.first_is_bang) begin
                        emit              = 1'b1;
                        stop              = 1'b1;
                        result.event_kind = EVENT_STOP;
                    end else if (cur_state.hash_seen) begin
                        if (!cur_state.data_done && cur_state.pair_phase != PHASE_NONE) begin
                            fin = store_byte(cur_state,
                                (cur_state.pair_phase == PHASE_DIGIT) ?
                                {cur_state.high_nibble, 4'h0} : 8'h00);
                        end
                        emit              = 1'b1;
                        result.event_kind = EVENT_FRAME;
                        result.frame_id   = fin.latched_id;
                        result.byte_count = fin.data_count;
                        result.payload    = fin.data_bytes;
                    end
                    next_state = '0;
                end
            end else if (cur_state.line_length < LINE_KEEP_MAX) begin
                if (cur_state.line_length == '0 && char_in == CHAR_BANG) begin
                    next_state.first_is_bang = 1'b1;
                end
                if (!cur_state.hash_seen) begin
                    if (char_in == CHAR_HASH) begin
                        next_state.latched_id = cur_state.token_value;
                        next_state.hash_seen  = 1'b1;
                    end else if (char_in == CHAR_SPACE) begin
                        next_state.token_value = '0;
                        next_state.token_ended = 1'b0;
                    end else if (!cur_state.token_ended) begin
                        if (!hex.is_hex) begin
                            next_state.token_ended = 1'b1;
                        end else if (cur_state.token_value[ID_W-1 -: 4] != 4'h0) begin
                            next_state.token_value = '1;
                        end else begin
                            next_state.token_value = {cur_state.token_value[ID_W-5:0], hex.value};
                        end
                    end
                end else if (!cur_state.data_done) begin
                    case (cur_state.pair_phase)
                        PHASE_NONE: begin
                            next_state.pair_phase  = hex.is_hex ? PHASE_DIGIT : PHASE_OTHER;
                            next_state.high_nibble = hex.is_hex ? hex.value : 4'h0;
                        end
                        PHASE_DIGIT: begin
                            next_state = store_byte(cur_state, hex.is_hex ?
                                {cur_state.high_nibble, hex.value} :
                                {4'h0, cur_state.high_nibble});
                        end
                        default: begin
                            next_state = store_byte(cur_state, 8'h00);
                        end
                    endcase
                end
                next_state.line_length = cur_state.line_length + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/can_log_line_parser_unit.sv @@
// Log line parser top level: input register, line state, playback enable and result register.
// The result request is registered: an accepted character passes the input register, then the result register.
// Throughput: one character per cycle while m_ready is high; the single parse step between
// the input register and the result register sets that figure.
// Reset (aresetn, synchronous, active low) clears the line state, the enable and both stages.
// Depends on clp_pkg and clp_line_core.
`default_nettype none

module can_log_line_parser_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_char_in,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_event_kind,
    output logic [31:0]      m_frame_id,
    output logic [3:0]       m_byte_count,
    output logic [63:0]      m_payload
);
    import clp_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  char_reg;
    logic        play_reg;
    clp_state_t  state_reg;
    clp_state_t  state_next;
    logic        out_valid_reg;
    clp_result_t out_reg;
    clp_result_t result;
    logic        emit;
    logic        stop;
    logic        advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    clp_line_core u_core (
        .play_en    (play_reg),
        .char_in    (char_reg),
        .cur_state  (state_reg),
        .next_state (state_next),
        .emit       (emit),
        .stop       (stop),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            play_reg      <= 1'b0;
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (cfg_wr_en) begin
                play_reg <= cfg_wr_data;
            end else if (advance && stop) begin
                play_reg <= 1'b0;
            end
            if (advance) begin
                state_reg     <= state_next;
                out_valid_reg <= emit;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            char_reg <= s_char_in;
        end
        if (advance && emit) begin
            out_reg <= result;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_event_kind = out_reg.event_kind;
    assign m_frame_id   = out_reg.frame_id;
    assign m_byte_count = out_reg.byte_count;
    assign m_payload    = out_reg.payload;

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for can_log_line_parser_unit: directed log lines checked mostly against
// results written in a table, then random lines checked against a line parser predictor in this file.
// Depends on clp_pkg and the parser RTL only.
`timescale 1ns / 1ps

module tb_top;
    import clp_pkg::*;

    typedef struct {
        string       text;
        bit          typed;
        clp_result_t res;
        int          pause_at;
    } log_row_t;

    logic aclk        = 1'b0;
    logic aresetn     = 1'b0;
    logic cfg_wr_en   = 1'b0;
    logic cfg_wr_data = 1'b0;
    logic s_valid     = 1'b0;
    logic [7:0] s_char_in = 8'h00;
    logic m_ready     = 1'b0;
    wire        s_ready;
    wire        m_valid;
    wire        m_event_kind;
    wire [31:0] m_frame_id;
    wire [3:0]  m_byte_count;
    wire [63:0] m_payload;

    // Predicted parser state.
    logic                  play_on;
    logic [LINE_LEN_W-1:0] kept_len;
    logic                  bang_first;
    logic                  hash_got;
    logic [31:0]           tok_val;
    logic                  tok_done;
    logic [31:0]           id_held;
    logic [63:0]           data_acc;
    logic [3:0]            data_cnt;
    logic [1:0]            pair_state;
    logic [3:0]            hi_nib;
    logic                  bytes_done;

    clp_result_t frames_due[$];
    log_row_t    log_rows[$];
    logic [7:0]  line_buf[$];
    bit          typed_due;
    clp_result_t typed_res;
    int          error_count = 0;
    int          chars_taken = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    logic        hold_tog    = 1'b0;
    logic        hold_seen   = 1'b0;
    int          hold_left   = 0;
    string       hex_chars   = "0123456789abcdefABCDEF";

    can_log_line_parser_unit i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_char_in    (s_char_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_event_kind (m_event_kind),
        .m_frame_id   (m_frame_id),
        .m_byte_count (m_byte_count),
        .m_payload    (m_payload)
    );

    always #5 aclk = ~aclk;

    function automatic int digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    function automatic logic [7:0] rand_hex();
        return hex_chars[$urandom_range(0, 21)];
    endfunction

    function automatic logic [7:0] rand_text();
        logic [7:0] c;
        do c = 8'($urandom_range(33, 126)); while (c == CHAR_HASH);
        return c;
    endfunction

    function automatic logic [7:0] rand_other();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (digit_value(c) >= 0 || c == CHAR_LF || c == CHAR_CR);
        return c;
    endfunction

    function automatic clp_result_t frame_of(input logic [31:0] id, input logic [3:0] n,
                                             input logic [63:0] p);
        clp_result_t r;
        r.event_kind = EVENT_FRAME;
        r.frame_id   = id;
        r.byte_count = n;
        r.payload    = p;
        return r;
    endfunction

    task automatic clear_line_state();
        kept_len   = '0;
        bang_first = 1'b0;
        hash_got   = 1'b0;
        tok_val    = '0;
        tok_done   = 1'b0;
        id_held    = '0;
        data_acc   = '0;
        data_cnt   = '0;
        pair_state = PHASE_NONE;
        hi_nib     = '0;
        bytes_done = 1'b0;
    endtask

    task automatic push_byte(input logic [7:0] b);
        if (data_cnt < BYTE_LIMIT) begin
            data_acc = data_acc | (64'(b) << (8 * data_cnt));
            data_cnt = data_cnt + 4'd1;
        end
        pair_state = PHASE_NONE;
        if (data_cnt >= BYTE_LIMIT) bytes_done = 1'b1;
    endtask

    task automatic parse_char(input logic [7:0] c, output bit emit, output clp_result_t r);
        int d;
        logic [35:0] v;
        emit = 1'b0;
        r    = '0;
        if (!play_on) return;
        if (c == CHAR_LF || c == CHAR_CR) begin
            if (kept_len == 0) return;
            if (bang_first) begin
                r.event_kind = EVENT_STOP;
                emit         = 1'b1;
                play_on      = 1'b0;
            end else if (hash_got) begin
                if (!bytes_done && pair_state != PHASE_NONE) begin
                    push_byte(pair_state == PHASE_DIGIT ? {hi_nib, 4'h0} : 8'h00);
                end
                r    = frame_of(id_held, data_cnt, data_acc);
                emit = 1'b1;
            end
            clear_line_state();
            return;
        end
        if (kept_len >= LINE_KEEP_MAX) return;
        d = digit_value(c);
        if (kept_len == 0 && c == CHAR_BANG) bang_first = 1'b1;
        if (!hash_got) begin
            if (c == CHAR_HASH) begin
                id_held  = tok_val;
                hash_got = 1'b1;
            end else if (c == CHAR_SPACE) begin
                tok_val  = '0;
                tok_done = 1'b0;
            end else if (!tok_done) begin
                if (d < 0) begin
                    tok_done = 1'b1;
                end else begin
                    v       = {tok_val, 4'(d)};
                    tok_val = (v[35:32] != 4'h0) ? 32'hFFFF_FFFF : v[31:0];
                end
            end
        end else if (!bytes_done) begin
            case (pair_state)
                PHASE_NONE: begin
                    if (d < 0) begin
                        pair_state = PHASE_OTHER;
                        hi_nib     = 4'h0;
                    end else begin
                        pair_state = PHASE_DIGIT;
                        hi_nib     = 4'(d);
                    end
                end
                PHASE_DIGIT: begin
                    push_byte(d < 0 ? {4'h0, hi_nib} : {hi_nib, 4'(d)});
                end
                default: begin
                    push_byte(8'h00);
                end
            endcase
        end
        kept_len = kept_len + 1'b1;
    endtask

    task automatic send_char(input logic [7:0] c);
        bit emit;
        clp_result_t r;
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < tx_idle_pct) gap = $urandom_range(1, 4);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_char_in <= c;
        do @(posedge aclk); while (!s_ready);
        if (play_on) chars_taken++;
        parse_char(c, emit, r);
        if (emit) begin
            if (typed_due) begin
                frames_due.push_back(typed_res);
                typed_due = 1'b0;
            end else begin
                frames_due.push_back(r);
            end
        end
    endtask

    // A caret in the text stands for a NUL character.
    task automatic send_text(input string t);
        logic [7:0] c;
        for (int i = 0; i < t.len(); i++) begin
            c = t[i];
            if (c == "^") c = 8'h00;
            send_char(c);
        end
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_play(input logic v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        play_on = v;
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_idle(input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
    endtask

    task automatic add_row(input string t, input bit ty, input clp_result_t r, input int p);
        log_row_t row;
        row.text     = t;
        row.typed    = ty;
        row.res      = r;
        row.pause_at = p;
        log_rows.push_back(row);
    endtask

    task automatic build_line();
        int pick;
        int n;
        line_buf.delete();
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            if ($urandom_range(0, 1) == 1) begin
                repeat ($urandom_range(1, 2)) begin
                    repeat ($urandom_range(1, 6)) line_buf.push_back(rand_text());
                    line_buf.push_back(CHAR_SPACE);
                    if ($urandom_range(0, 7) == 0) line_buf.push_back(CHAR_SPACE);
                end
            end
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
            repeat (n) line_buf.push_back(rand_hex());
            if ($urandom_range(0, 9) == 0) line_buf.push_back(rand_text());
            line_buf.push_back(CHAR_HASH);
            repeat ($urandom_range(0, 18)) begin
                line_buf.push_back(($urandom_range(0, 11) == 0) ? rand_other() : rand_hex());
            end
        end else if (pick < 79) begin
            line_buf.push_back(CHAR_BANG);
            repeat ($urandom_range(0, 5)) line_buf.push_back(rand_text());
        end else if (pick < 95) begin
            repeat ($urandom_range(0, 10)) line_buf.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(60, 100)) begin
                n = $urandom_range(0, 9);
                if (n < 6) line_buf.push_back(rand_hex());
                else if (n < 8) line_buf.push_back(CHAR_SPACE);
                else if (n < 9) line_buf.push_back(CHAR_HASH);
                else line_buf.push_back(rand_other());
            end
        end
        case ($urandom_range(0, 2))
            0: begin
                line_buf.push_back(CHAR_LF);
            end
            1: begin
                line_buf.push_back(CHAR_CR);
            end
            default: begin
                line_buf.push_back(CHAR_CR);
                line_buf.push_back(CHAR_LF);
            end
        endcase
    endtask

    always @(posedge aclk) begin
        if (hold_tog != hold_seen) begin
            hold_seen <= hold_tog;
            hold_left <= 300;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin : result_check
        clp_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (frames_due.size() == 0) begin
                $error("result request with none expected: kind %0b id %h count %0d data %h",
                       m_event_kind, m_frame_id, m_byte_count, m_payload);
                error_count++;
            end else begin
                want = frames_due.pop_front();
                if (m_event_kind !== want.event_kind) begin
                    $error("event_kind: expected %0b, actual %0b", want.event_kind,
                           m_event_kind);
                    error_count++;
                end
                if (m_frame_id !== want.frame_id) begin
                    $error("frame_id: expected %h, actual %h", want.frame_id, m_frame_id);
                    error_count++;
                end
                if (m_byte_count !== want.byte_count) begin
                    $error("byte_count: expected %0d, actual %0d", want.byte_count,
                           m_byte_count);
                    error_count++;
                end
                if (m_payload !== want.payload) begin
                    $error("payload: expected %h, actual %h", want.payload, m_payload);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        string sp;
        int target;
        int lines;
        play_on   = 1'b0;
        typed_due = 1'b0;
        typed_res = '0;
        clear_line_state();

        add_row("7FF#\n", 1, frame_of(32'h7FF, 4'd0, 64'd0), -1);
        add_row("FFFFFFFFF#00\n", 1, frame_of(32'hFFFF_FFFF, 4'd1, 64'd0), -1);
        add_row("1 2#0102030405060708090A\n", 1,
                frame_of(32'h2, 4'd8, 64'h0807_0605_0403_0201), -1);
        add_row("0#FFFFFFFFFFFFFFFF\r", 1, frame_of(32'h0, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF), -1);
        add_row("5#A\n", 1, frame_of(32'h5, 4'd1, 64'hA0), -1);
        add_row("\n", 0, '0, -1);
        add_row("hello\r\n", 0, '0, -1);
        add_row("#12\n", 1, frame_of(32'h0, 4'd1, 64'h12), -1);
        add_row("x3#\n", 1, frame_of(32'h0, 4'd0, 64'h0), -1);
        add_row("12z4#\n", 1, frame_of(32'h12, 4'd0, 64'h0), -1);
        add_row("3#1z\n", 1, frame_of(32'h3, 4'd1, 64'h01), -1);
        add_row("3#z1\n", 1, frame_of(32'h3, 4'd1, 64'h00), -1);
        add_row("3#12#4\n", 1, frame_of(32'h3, 4'd2, 64'h0012), -1);
        add_row("6#^\001AB\n", 1, frame_of(32'h6, 4'd2, 64'hAB00), -1);
        add_row("2#\377\200\n", 1, frame_of(32'h2, 4'd1, 64'h0), -1);
        add_row("a!#1\n", 1, frame_of(32'hA, 4'd1, 64'h10), -1);
        add_row("!ab#12\n", 1, clp_result_t'({EVENT_STOP, 32'd0, 4'd0, 64'd0}), -1);
        add_row("1FFFFFFFF #5\n", 1, frame_of(32'h0, 4'd1, 64'h50), -1);
        add_row("can0 123#DEADBEEF\r", 1, frame_of(32'h123, 4'd4, 64'hEFBE_ADDE), -1);
        add_row("1#0011223344556677889\n", 1,
                frame_of(32'h1, 4'd8, 64'h7766_5544_3322_1100), -1);
        add_row("1#23\n", 1, frame_of(32'h1, 4'd1, 64'h23), 3);
        sp = "";
        repeat (77) sp = {sp, " "};
        add_row({sp, "5#\n"}, 1, frame_of(32'h5, 4'd0, 64'h0), -1);
        add_row({sp, " 5#11\n"}, 0, '0, -1);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Playback is off after reset, so this line must not give a result.
        set_idle(27, 49);
        send_text("1#\n");
        settle();
        write_play(1'b1);

        foreach (log_rows[k]) begin
            typed_due = log_rows[k].typed;
            typed_res = log_rows[k].res;
            if (log_rows[k].pause_at < 0) begin
                send_text(log_rows[k].text);
            end else begin
                send_text(log_rows[k].text.substr(0, log_rows[k].pause_at - 1));
                settle();
                write_play(1'b0);
                send_text("9#9\n");
                settle();
                write_play(1'b1);
                send_text(log_rows[k].text.substr(log_rows[k].pause_at,
                                                  log_rows[k].text.len() - 1));
            end
            if (!play_on) begin
                settle();
                write_play(1'b1);
            end
        end
        typed_due = 1'b0;
        settle();

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    set_idle(27, 49);
                end
                1: begin
                    set_idle(49, 27);
                end
                default: begin
                    set_idle(0, 0);
                    hold_tog <= ~hold_tog;
                end
            endcase
            target = chars_taken + 280;
            lines  = 0;
            while (chars_taken < target) begin
                build_line();
                foreach (line_buf[i]) send_char(line_buf[i]);
                lines++;
                if (lines == 15) settle();
                if (!play_on) begin
                    if ($urandom_range(0, 1) == 1) begin
                        build_line();
                        foreach (line_buf[i]) send_char(line_buf[i]);
                    end
                    settle();
                    write_play(1'b1);
                end
            end
            settle();
            write_play(1'b0);
            write_play(1'b1);
        end

        settle();
        repeat (10) @(posedge aclk);
        if (error_count == 0 && frames_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
